// ===== rtl/ctsa_pkg.sv =====
`timescale 1ns / 1ps

package ctsa_pkg;

   localparam int SLOT_COUNT_DEFAULT = 32;
   localparam int ID_BITS_DEFAULT    = 29;
   localparam int OP_BITS            = 3;
   localparam int SLOT_IDX_BITS      = 5;
   localparam int RESERVED_BITS      = 6;

   localparam logic [OP_BITS-1:0] OP_ALLOCATE  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_CANCEL    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_TX_DONE   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_ACK_ERROR = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR_ALL = 3'd4;

   typedef struct packed {
      logic claim;
      logic release_slot;
      logic clear_all;
   } tbl_cmd_type;

   typedef struct packed {
      logic busy;
      logic match;
   } tbl_stat_type;

endpackage

// ===== rtl/can_tx_slot_allocator_top.sv =====
`timescale 1ns / 1ps

// CAN transmit slot allocator.
// Requests enter on start while busy is low, with req_operation selecting
// allocate, cancel stalled, transmit done, acknowledge error or clear all.
// Each request gives one result: rsp_strobe is high for exactly one cycle
// with rsp_granted, rsp_slot_out and rsp_freed_mask valid in that cycle.
// The receiver cannot stall; busy stays high from acceptance through the
// strobe cycle, and the next request can be taken the cycle after it.
// One slot position is examined per cycle by a single compare unit. An
// allocate scans up from reserved_count and, if no slot is usable,
// releases stalled slots and rescans; a cancel makes one release pass,
// an acknowledge error scans from slot 0 to the first requested slot and
// a transmit done visits the named slot. Clear all, undefined operations
// and an allocate or cancel with no usable slot go straight to the strobe.
// csr_write_enable writes reserved_count from csr_write_data; write it only
// while busy is low. Reset (synchronous, active high) frees every slot,
// clears reserved_count and returns the sequencer to idle. Slot owners are
// not cleared; they are read only for busy slots.
module can_tx_slot_allocator_top #(
   parameter int SLOT_COUNT = ctsa_pkg::SLOT_COUNT_DEFAULT,
   parameter int ID_BITS    = ctsa_pkg::ID_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ctsa_pkg::OP_BITS-1:0]         req_operation,
   input  logic [ID_BITS-1:0]                   req_frame_id,
   input  logic [ctsa_pkg::SLOT_IDX_BITS-1:0]   req_slot_in,
   input  logic [SLOT_COUNT-1:0]                req_slot_mask,
   output logic                                 rsp_strobe,
   output logic                                 rsp_granted,
   output logic [ctsa_pkg::SLOT_IDX_BITS-1:0]   rsp_slot_out,
   output logic [SLOT_COUNT-1:0]                rsp_freed_mask,
   input  logic                                 csr_write_enable,
   input  logic [ctsa_pkg::RESERVED_BITS-1:0]   csr_write_data
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [SLOT_COUNT-1:0] ONE_BIT = SLOT_COUNT'(1);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SCAN    = 6'b000010,
      ST_RELEASE = 6'b000100,
      ST_ACK     = 6'b001000,
      ST_RELONE  = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   state_type                              state_ff, state_in;
   logic [ctsa_pkg::RESERVED_BITS-1:0]     reserved_ff;
   logic [ctsa_pkg::OP_BITS-1:0]           op_ff, op_in;
   logic [ID_BITS-1:0]                     id_ff, id_in;
   logic [SLOT_COUNT-1:0]                  mask_ff, mask_in;
   logic [SLOT_W-1:0]                      idx_ff, idx_in;
   logic                                   retry_ff, retry_in;
   logic                                   granted_ff, granted_in;
   logic [ctsa_pkg::SLOT_IDX_BITS-1:0]     slot_ff, slot_in;
   logic [SLOT_COUNT-1:0]                  freed_ff, freed_in;

   ctsa_pkg::tbl_cmd_type                  cmd;
   ctsa_pkg::tbl_stat_type                 stat;
   logic [SLOT_COUNT-1:0]                  busy_vec;
   logic                                   accept;
   logic                                   range_empty;
   logic                                   last_idx;
   logic [SLOT_W-1:0]                      first_idx;

   ctsa_slot_table #(
      .SLOT_COUNT (SLOT_COUNT),
      .ID_BITS    (ID_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .idx      (idx_ff),
      .id       (id_ff),
      .stat     (stat),
      .busy_vec (busy_vec)
   );

   assign accept      = start && (state_ff == ST_IDLE);
   assign range_empty = (reserved_ff >= ctsa_pkg::RESERVED_BITS'(SLOT_COUNT));
   assign first_idx   = reserved_ff[SLOT_W-1:0];
   assign last_idx    = (idx_ff == LAST_IDX);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      retry_in   = retry_ff;
      granted_in = granted_ff;
      slot_in    = slot_ff;
      freed_in   = freed_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_operation;
               id_in      = req_frame_id;
               mask_in    = req_slot_mask;
               retry_in   = 1'b0;
               granted_in = 1'b0;
               slot_in    = '0;
               freed_in   = '0;
               idx_in     = first_idx;
               unique case (req_operation)
                  ctsa_pkg::OP_ALLOCATE: begin
                     state_in = range_empty ? ST_DONE : ST_SCAN;
                  end
                  ctsa_pkg::OP_CANCEL: begin
                     state_in = range_empty ? ST_DONE : ST_RELEASE;
                  end
                  ctsa_pkg::OP_TX_DONE: begin
                     idx_in   = req_slot_in[SLOT_W-1:0];
                     state_in = (req_slot_in >= ctsa_pkg::SLOT_IDX_BITS'(SLOT_COUNT - 1) + 1'b1
                                 && SLOT_COUNT < 32) ? ST_DONE : ST_RELONE;
                  end
                  ctsa_pkg::OP_ACK_ERROR: begin
                     idx_in   = '0;
                     state_in = ST_ACK;
                  end
                  ctsa_pkg::OP_CLEAR_ALL: begin
                     cmd.clear_all = 1'b1;
                     freed_in      = busy_vec;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stat.busy || stat.match) begin
               cmd.claim  = 1'b1;
               granted_in = 1'b1;
               slot_in    = ctsa_pkg::SLOT_IDX_BITS'(idx_ff);
               state_in   = ST_DONE;
            end else if (last_idx) begin
               idx_in   = first_idx;
               state_in = retry_ff ? ST_DONE : ST_RELEASE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RELEASE: begin
            if (mask_ff[idx_ff] && stat.busy) begin
               cmd.release_slot = 1'b1;
               freed_in         = freed_ff | (ONE_BIT << idx_ff);
            end
            if (last_idx) begin
               // allocate retries the scan once after the stall release
               idx_in   = first_idx;
               retry_in = 1'b1;
               state_in = (op_ff == ctsa_pkg::OP_ALLOCATE) ? ST_SCAN : ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_ACK: begin
            if (mask_ff[idx_ff]) begin
               if (stat.busy) begin
                  cmd.release_slot = 1'b1;
                  freed_in         = ONE_BIT << idx_ff;
               end
               state_in = ST_DONE;
            end else if (last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RELONE: begin
            if (stat.busy) begin
               cmd.release_slot = 1'b1;
               freed_in         = ONE_BIT << idx_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         reserved_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            reserved_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      mask_ff    <= mask_in;
      idx_ff     <= idx_in;
      retry_ff   <= retry_in;
      granted_ff <= granted_in;
      slot_ff    <= slot_in;
      freed_ff   <= freed_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = (state_ff == ST_DONE);
   assign rsp_granted    = granted_ff;
   assign rsp_slot_out   = slot_ff;
   assign rsp_freed_mask = freed_ff;

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("strobe not followed by idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_granted) |-> (rsp_slot_out == '0))
      else $error("failed allocation reports nonzero slot");

   a_grant_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_granted) |-> busy_vec[rsp_slot_out[SLOT_W-1:0]])
      else $error("granted slot is not marked busy");

   a_grant_owner: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_granted) |-> (op_ff == ctsa_pkg::OP_ALLOCATE))
      else $error("grant reported for a non-allocate request");

endmodule

// ===== rtl/ctsa_slot_table.sv =====
`timescale 1ns / 1ps

module ctsa_slot_table #(
   parameter int SLOT_COUNT = ctsa_pkg::SLOT_COUNT_DEFAULT,
   parameter int ID_BITS    = ctsa_pkg::ID_BITS_DEFAULT,
   localparam int SLOT_W    = $clog2(SLOT_COUNT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctsa_pkg::tbl_cmd_type   cmd,
   input  logic [SLOT_W-1:0]       idx,
   input  logic [ID_BITS-1:0]      id,
   output ctsa_pkg::tbl_stat_type  stat,
   output logic [SLOT_COUNT-1:0]   busy_vec
);

   logic [SLOT_COUNT-1:0] busy_ff;
   logic [SLOT_COUNT-1:0] busy_in;
   logic [ID_BITS-1:0]    owner_ff [SLOT_COUNT];

   always_comb begin
      busy_in = busy_ff;
      if (cmd.clear_all) begin
         busy_in = '0;
      end else if (cmd.claim) begin
         busy_in[idx] = 1'b1;
      end else if (cmd.release_slot) begin
         busy_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.claim) begin
         owner_ff[idx] <= id;
      end
   end

   // shared identifier compare at the scan position
   assign stat.busy  = busy_ff[idx];
   assign stat.match = (owner_ff[idx] == id);
   assign busy_vec   = busy_ff;

endmodule

// ===== tb/tb_can_tx_slot_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_can_tx_slot_allocator_top;

   localparam int NSLOT = 32;
   localparam int IDW   = 29;
   localparam logic [ctsa_pkg::OP_BITS-1:0] OP_UNDEF_LO  = 3'd5;
   localparam logic [ctsa_pkg::OP_BITS-1:0] OP_UNDEF_MID = 3'd6;
   localparam logic [ctsa_pkg::OP_BITS-1:0] OP_UNDEF_HI  = 3'd7;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 3 * NSLOT + 16;

   typedef struct packed {
      logic [ctsa_pkg::OP_BITS-1:0]       op;
      logic [IDW-1:0]                     id;
      logic [ctsa_pkg::SLOT_IDX_BITS-1:0] slot;
      logic [NSLOT-1:0]                   mask;
   } slot_req_type;

   typedef struct packed {
      logic                               granted;
      logic [ctsa_pkg::SLOT_IDX_BITS-1:0] slot;
      logic [NSLOT-1:0]                   freed;
   } slot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ctsa_pkg::OP_BITS-1:0]       req_operation = '0;
   logic [IDW-1:0]                     req_frame_id = '0;
   logic [ctsa_pkg::SLOT_IDX_BITS-1:0] req_slot_in = '0;
   logic [NSLOT-1:0]                   req_slot_mask = '0;
   logic                               rsp_strobe;
   logic                               rsp_granted;
   logic [ctsa_pkg::SLOT_IDX_BITS-1:0] rsp_slot_out;
   logic [NSLOT-1:0]                   rsp_freed_mask;
   logic                               csr_write_enable = 1'b0;
   logic [ctsa_pkg::RESERVED_BITS-1:0] csr_write_data = '0;

   // predictor state
   logic                               tbl_busy [NSLOT];
   logic [IDW-1:0]                     tbl_owner [NSLOT];
   logic [ctsa_pkg::RESERVED_BITS-1:0] cur_reserved = '0;

   slot_req_type pending_req_q[$];
   slot_rsp_type expected_rsp_q[$];

   int issued_cnt = 0;
   int accepted_cnt = 0;
   int fail_count = 0;
   int stall_cycles = 0;
   int grant_cnt = 0;
   int alloc_fail_cnt = 0;
   int stall_free_cnt = 0;
   int setting_cnt = 0;
   logic no_gaps = 1'b0;

   can_tx_slot_allocator_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_frame_id     (req_frame_id),
      .req_slot_in      (req_slot_in),
      .req_slot_mask    (req_slot_mask),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted      (rsp_granted),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_freed_mask   (rsp_freed_mask),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int claim_slot(logic [IDW-1:0] id);
      int got;
      got = -1;
      for (int i = int'(cur_reserved); i < NSLOT; i++) begin
         if (got < 0 && (!tbl_busy[i] || tbl_owner[i] == id)) begin
            tbl_busy[i] = 1'b1;
            tbl_owner[i] = id;
            got = i;
         end
      end
      return got;
   endfunction

   function automatic logic [NSLOT-1:0] free_pending(logic [NSLOT-1:0] pend);
      logic [NSLOT-1:0] freed;
      freed = '0;
      for (int i = int'(cur_reserved); i < NSLOT; i++) begin
         if (pend[i] && tbl_busy[i]) begin
            tbl_busy[i] = 1'b0;
            freed[i] = 1'b1;
         end
      end
      return freed;
   endfunction

   function automatic logic [NSLOT-1:0] free_one(int idx);
      logic [NSLOT-1:0] freed;
      freed = '0;
      if (idx < NSLOT && tbl_busy[idx]) begin
         tbl_busy[idx] = 1'b0;
         freed[idx] = 1'b1;
      end
      return freed;
   endfunction

   function automatic slot_rsp_type predict_slot_op(slot_req_type r);
      slot_rsp_type res;
      int got;
      logic found;
      res = '0;
      found = 1'b0;
      case (r.op)
         ctsa_pkg::OP_ALLOCATE: begin
            got = claim_slot(r.id);
            if (got < 0) begin
               res.freed = free_pending(r.mask);
               got = claim_slot(r.id);
            end
            if (got >= 0) begin
               res.granted = 1'b1;
               res.slot = ctsa_pkg::SLOT_IDX_BITS'(got);
            end
         end
         ctsa_pkg::OP_CANCEL:   res.freed = free_pending(r.mask);
         ctsa_pkg::OP_TX_DONE:  res.freed = free_one(int'(r.slot));
         ctsa_pkg::OP_ACK_ERROR: begin
            // only the lowest requested slot counts, busy or not
            for (int i = 0; i < NSLOT; i++) begin
               if (!found && r.mask[i]) begin
                  found = 1'b1;
                  res.freed = free_one(i);
               end
            end
         end
         ctsa_pkg::OP_CLEAR_ALL: begin
            for (int i = 0; i < NSLOT; i++)
               res.freed |= free_one(i);
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void queue_req(logic [ctsa_pkg::OP_BITS-1:0] op,
                                     logic [IDW-1:0] id,
                                     logic [ctsa_pkg::SLOT_IDX_BITS-1:0] slot,
                                     logic [NSLOT-1:0] mask);
      slot_req_type r;
      r.op = op;
      r.id = id;
      r.slot = slot;
      r.mask = mask;
      pending_req_q.push_back(r);
   endfunction

   function automatic logic [IDW-1:0] rand_id();
      // mostly a small pool so owners repeat and the table fills up
      if ($urandom_range(0, 99) < 70)
         return IDW'($urandom_range(0, 47) * 32'h0123_4567);
      return IDW'($urandom);
   endfunction

   function automatic logic [NSLOT-1:0] rand_mask();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return NSLOT'($urandom);
         3: return NSLOT'($urandom & $urandom);
         default: return NSLOT'(1) << $urandom_range(0, NSLOT - 1);
      endcase
   endfunction

   function automatic void queue_random_req();
      int pick;
      logic [ctsa_pkg::OP_BITS-1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 55)      op = ctsa_pkg::OP_ALLOCATE;
      else if (pick < 75) op = ctsa_pkg::OP_TX_DONE;
      else if (pick < 86) op = ctsa_pkg::OP_ACK_ERROR;
      else if (pick < 94) op = ctsa_pkg::OP_CANCEL;
      else if (pick < 97) op = ctsa_pkg::OP_CLEAR_ALL;
      else op = ctsa_pkg::OP_BITS'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      queue_req(op, rand_id(), ctsa_pkg::SLOT_IDX_BITS'($urandom), rand_mask());
   endfunction

   task automatic wait_idle();
      while (!(pending_req_q.size() == 0 && !start && expected_rsp_q.size() == 0))
         @(negedge clock);
      @(negedge clock);
      while (busy)
         @(negedge clock);
   endtask

   task automatic write_reserved(logic [ctsa_pkg::RESERVED_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_reserved = value;
      setting_cnt++;
   endtask

   // driver: present one request at a time, hold it until accepted
   always @(negedge clock) begin : drv
      slot_req_type r;
      logic holding;
      if (!reset) begin
         holding = start && (accepted_cnt != issued_cnt);
         if (!holding) begin
            if (pending_req_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
               r = pending_req_q.pop_front();
               req_operation <= r.op;
               req_frame_id <= r.id;
               req_slot_in <= r.slot;
               req_slot_mask <= r.mask;
               start <= 1'b1;
               issued_cnt++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: check results, predict on each accepted request, watchdog
   always @(posedge clock) begin : mon
      slot_rsp_type want;
      slot_rsp_type got;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_strobe) begin
            moved = 1'b1;
            got.granted = rsp_granted;
            got.slot = rsp_slot_out;
            got.freed = rsp_freed_mask;
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: result with none expected: granted=%0b slot=%0d freed=%08h",
                           got.granted, got.slot, got.freed);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.granted !== want.granted || got.slot !== want.slot ||
                   got.freed !== want.freed) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("ERROR: at %0t expected granted=%0b slot=%0d freed=%08h,",
                              $realtime, want.granted, want.slot, want.freed);
                     $display("       got granted=%0b slot=%0d freed=%08h",
                              got.granted, got.slot, got.freed);
                  end
               end
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            accepted_cnt++;
            want = predict_slot_op({req_operation, req_frame_id, req_slot_in, req_slot_mask});
            if (req_operation == ctsa_pkg::OP_ALLOCATE) begin
               if (want.granted) grant_cnt++;
               else alloc_fail_cnt++;
               if (want.freed != '0) stall_free_cnt++;
            end
            expected_rsp_q.push_back(want);
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_can_tx_slot_allocator_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int phase_reserved [6];
      int phase_items [6];
      for (int i = 0; i < NSLOT; i++) begin
         tbl_busy[i] = 1'b0;
         tbl_owner[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reserved(6'd0);
      queue_req(ctsa_pkg::OP_ALLOCATE, '0, '0, '0);
      queue_req(ctsa_pkg::OP_ALLOCATE, '1, '1, '0);
      queue_req(ctsa_pkg::OP_ALLOCATE, '0, '0, '1);       // same owner reuses its slot
      queue_req(ctsa_pkg::OP_TX_DONE, '0, 5'd31, '0);     // free slot, nothing changes
      queue_req(ctsa_pkg::OP_TX_DONE, '1, 5'd1, '1);
      queue_req(ctsa_pkg::OP_ACK_ERROR, '0, '0, '0);      // empty request mask
      queue_req(ctsa_pkg::OP_ACK_ERROR, '0, '0, 32'h8000_0001);
      queue_req(ctsa_pkg::OP_ACK_ERROR, '0, '0, 32'h0000_0020);
      queue_req(OP_UNDEF_LO, '1, '1, '1);
      queue_req(OP_UNDEF_MID, 29'h0AAA_AAAA, 5'd21, 32'h5555_5555);
      queue_req(OP_UNDEF_HI, 29'h1555_5555, 5'd10, 32'hAAAA_AAAA);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'h155, '0, '0);
      queue_req(ctsa_pkg::OP_CLEAR_ALL, '0, '0, '0);
      wait_idle();

      // two usable slots: fill them, fail, then release stalled ones
      write_reserved(6'd30);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'd1, '0, '0);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'd2, '0, '0);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'd3, '0, '0);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'd3, '0, '1);
      queue_req(ctsa_pkg::OP_CANCEL, '0, '0, '1);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'd7, '0, '0);
      wait_idle();

      // nothing allocatable
      write_reserved(6'd32);
      queue_req(ctsa_pkg::OP_ALLOCATE, 29'd4, '0, '1);
      queue_req(ctsa_pkg::OP_CANCEL, '0, '0, '1);
      queue_req(ctsa_pkg::OP_TX_DONE, '0, 5'd31, '0);     // ignores the reserved count
      queue_req(ctsa_pkg::OP_CLEAR_ALL, '0, '0, '0);
      wait_idle();

      phase_reserved = '{0, 31, $urandom_range(1, 29), 32, $urandom_range(16, 30), 0};
      phase_items = '{260, 180, 240, 60, 230, 280};
      for (int p = 0; p < 6; p++) begin
         write_reserved(ctsa_pkg::RESERVED_BITS'(phase_reserved[p]));
         no_gaps = (p == 2);
         for (int n = 0; n < phase_items[p]; n++)
            queue_random_req();
         wait_idle();
      end
      no_gaps = 1'b0;

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Ran %0d requests over %0d reserved-count settings: %0d grants,",
               accepted_cnt, setting_cnt, grant_cnt);
      $display("%0d failed allocations, %0d allocations that released stalled slots",
               alloc_fail_cnt, stall_free_cnt);
      if (expected_rsp_q.size() != 0)
         $display("ERROR: %0d results never arrived", expected_rsp_q.size());
      if (fail_count == 0 && expected_rsp_q.size() == 0)
         $display("tb_can_tx_slot_allocator_top OK");
      else
         $display("tb_can_tx_slot_allocator_top NOT OK");
      $finish;
   end

endmodule
